>>> src/upwind_edge_flux_cfl_step_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the upwind edge flux unit
// Shared property forms for same-cycle and next-cycle implications.
// ----------------------------------------------------------------------------
`ifndef UPWIND_EDGE_FLUX_CFL_STEP_UNIT_ASSERT_SVH
`define UPWIND_EDGE_FLUX_CFL_STEP_UNIT_ASSERT_SVH

// ante implies cons in the same cycle
`define UEFC_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("uefc: same-cycle check failed");

// ante implies cons in the next cycle
`define UEFC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("uefc: next-cycle check failed");

`endif

>>> src/uefc_pkg.sv
// ----------------------------------------------------------------------------
// uefc_pkg
// Widths, reset constants and divider handshake types of the upwind flux unit.
// ----------------------------------------------------------------------------
`default_nettype none

package uefc_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int DATA_W        = 32;
  localparam int NORM_W        = 16;
  localparam int NORM_FRAC     = 14;
  localparam int MUL_W         = DATA_W + 1;
  localparam int PROD_W        = 2 * MUL_W;
  localparam int NV_SUM_W      = DATA_W + NORM_W + 1;
  localparam int SUM_W         = 2 * DATA_W + 2;
  localparam int A_HI_W        = DATA_W + FRACTION_BITS;
  localparam int DIV_STEPS     = DATA_W;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS + 1);

  localparam logic [DATA_W-1:0] HUGE_STEP_RST = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0] MAX_STEP_RST  = 32'h0001_0000;
  localparam logic [DATA_W-1:0] POS_LIMIT     = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] NEG_LIMIT     = 32'h8000_0000;

  typedef enum logic [1:0] {
    REG_VELOCITY_X = 2'd0,
    REG_VELOCITY_Y = 2'd1,
    REG_HUGE_STEP  = 2'd2,
    REG_MAX_STEP   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] hi;
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> src/uefc_mul.sv
// ----------------------------------------------------------------------------
// uefc_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module uefc_mul (
  input  wire logic                                    clk_i,
  input  wire logic signed [uefc_pkg::MUL_W-1:0]       a_i,
  input  wire logic signed [uefc_pkg::MUL_W-1:0]       b_i,
  output      logic signed [uefc_pkg::PROD_W-1:0]      prod_o
);

  logic signed [uefc_pkg::PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

>>> src/uefc_div.sv
// ----------------------------------------------------------------------------
// uefc_div
// Restoring divider, one quotient bit per cycle; high word below divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module uefc_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire uefc_pkg::div_req_t req_i,
  output      uefc_pkg::div_rsp_t rsp_o
);

  logic [uefc_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                           done_q;
  logic [uefc_pkg::DATA_W-1:0]    rem_q;
  logic [uefc_pkg::DATA_W-1:0]    quo_q;
  logic [uefc_pkg::DATA_W-1:0]    dvs_q;
  logic [uefc_pkg::DATA_W:0]      trial;
  logic [uefc_pkg::DATA_W:0]      diff;
  logic                           q_bit;
  logic [uefc_pkg::DATA_W-1:0]    rem_nx;

  assign trial  = {rem_q, quo_q[uefc_pkg::DATA_W-1]};
  assign diff   = trial - {1'b0, dvs_q};
  assign q_bit  = !diff[uefc_pkg::DATA_W];
  assign rem_nx = q_bit ? diff[uefc_pkg::DATA_W-1:0] : trial[uefc_pkg::DATA_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        cnt_q <= uefc_pkg::DIV_CNT_W'(uefc_pkg::DIV_STEPS);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - uefc_pkg::DIV_CNT_W'(1);
        if (cnt_q == uefc_pkg::DIV_CNT_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.hi;
      quo_q <= req_i.lo;
      dvs_q <= req_i.divisor;
    end else if (cnt_q != '0) begin
      rem_q <= rem_nx;
      quo_q <= {quo_q[uefc_pkg::DATA_W-2:0], q_bit};
    end
  end

  assign rsp_o.busy = (cnt_q != '0);
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

`default_nettype wire

>>> src/upwind_edge_flux_cfl_step_unit.sv
// ----------------------------------------------------------------------------
// upwind_edge_flux_cfl_step_unit
// First-order upwind edge flux sum and CFL timestep bound, one edge per item.
// ----------------------------------------------------------------------------
// One item is one triangle edge; the block takes one item at a time. An edge
// without a timestep division passes the multiplier steps, the clamps and the
// flux accumulation before the block is ready again. A full cell edge with
// nonzero normal speed adds the radius over speed division unless the ratio
// overflows, and the last edge of a cell adds the area division, unless the
// area is zero or the quotient overflows, before its result goes to the
// output register. Both divisions run on the single 32-step restoring divider,
// and all products of an edge go through the one shared multiplier. A result
// waiting at the output does not hold off the next item until the next result is ready to replace it.
`default_nettype none
`include "upwind_edge_flux_cfl_step_unit_assert.svh"

module upwind_edge_flux_cfl_step_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // register write channel
  input  wire logic         cfg_valid_i,
  output      logic         cfg_ready_o,
  input  wire logic [1:0]   cfg_index_i,
  input  wire logic [31:0]  cfg_data_i,
  // edge items in
  input  wire logic         s_axis_tvalid_i,
  output      logic         s_axis_tready_o,
  // own_value, neighbour_value, normal_x, normal_y, edge_length, cell_area,
  // cell_radius
  input  wire logic [191:0] s_axis_tdata_i,
  input  wire logic         s_axis_tlast_i,   // last_edge
  input  wire logic [1:0]   s_axis_tuser_i,   // full_cell, new_sweep
  // cell results out
  output      logic         m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output      logic [63:0]  m_axis_tdata_o,   // flux_update, step_limit
  output      logic [0:0]   m_axis_tuser_o    // saturated
);

  localparam int F  = uefc_pkg::FRACTION_BITS;
  localparam int DW = uefc_pkg::DATA_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL_X, ST_MUL_Y, ST_NVEL, ST_MUL_E, ST_EF, ST_MUL_T,
    ST_ACC, ST_RDIV, ST_LAST, ST_AREA, ST_ADIV, ST_EMIT
  } state_e;

  state_e state_q;

  logic signed [DW-1:0] vel_x_q, vel_y_q;
  logic [DW-1:0]        huge_step_q, max_step_q;

  logic signed [DW-1:0]                 own_q, nbr_q;
  logic signed [uefc_pkg::NORM_W-1:0]   nx_q, ny_q;
  logic [DW-1:0]                        len_q, area_q, radius_q;
  logic                                 full_q, last_q;

  logic signed [2*DW-1:0]               flux_sum_q;
  logic [DW-1:0]                        cell_step_q, sweep_step_q;
  logic                                 cell_open_q, cell_sat_q;

  logic signed [uefc_pkg::NV_SUM_W-1:0] acc_q;
  logic signed [DW-1:0]                 nvel_q, ef_q;
  logic [2*DW-1:0]                      mag_q;
  logic                                 neg_q;
  logic [DW-1:0]                        res_q;
  logic                                 res_sat_q;

  logic                                 m_valid_q;
  logic [DW-1:0]                        out_flux_q, out_step_q;
  logic                                 out_sat_q;

  logic signed [uefc_pkg::MUL_W-1:0]    mul_a, mul_b;
  logic signed [uefc_pkg::PROD_W-1:0]   mul_prod;

  uefc_pkg::div_req_t div_req;
  uefc_pkg::div_rsp_t div_rsp;

  logic                                 in_acc;
  logic signed [uefc_pkg::NV_SUM_W-1:0] nv_sum;
  logic                                 nv_ovf;
  logic [DW-1:0]                        nv_sat;
  logic                                 ef_ovf;
  logic [DW-1:0]                        ef_sat;
  logic signed [uefc_pkg::SUM_W-1:0]    term_ext, flux_ext, flux_add;
  logic                                 flux_ovf;
  logic [2*DW-1:0]                      flux_nx;
  logic [DW-1:0]                        speed;
  logic [DW-1:0]                        r_hi, r_lo;
  logic                                 r_ovf;
  logic [uefc_pkg::A_HI_W-1:0]          a_hi;
  logic [DW-1:0]                        a_lo;
  logic                                 a_ovf;
  logic [DW-1:0]                        limit;
  logic                                 q_over;
  logic [DW-1:0]                        total, signed_res;

  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign cfg_ready_o     = 1'b1;

  // normal velocity, floor shift and clamp
  assign nv_sum = acc_q + $signed(mul_prod[uefc_pkg::NV_SUM_W-1:0]);
  assign nv_ovf = !((&nv_sum[uefc_pkg::NV_SUM_W-1:uefc_pkg::NORM_FRAC+DW-1]) ||
                    !(|nv_sum[uefc_pkg::NV_SUM_W-1:uefc_pkg::NORM_FRAC+DW-1]));
  assign nv_sat = nv_ovf ? (nv_sum[uefc_pkg::NV_SUM_W-1] ? uefc_pkg::NEG_LIMIT
                                                         : uefc_pkg::POS_LIMIT)
                         : nv_sum[uefc_pkg::NORM_FRAC+DW-1:uefc_pkg::NORM_FRAC];

  // edge flux, floor shift and clamp
  assign ef_ovf = !((&mul_prod[2*DW-1:DW-1+F]) || !(|mul_prod[2*DW-1:DW-1+F]));
  assign ef_sat = ef_ovf ? (mul_prod[2*DW-1] ? uefc_pkg::NEG_LIMIT : uefc_pkg::POS_LIMIT)
                         : mul_prod[DW-1+F:F];

  // flux sum minus term, clamped to 64 bits
  assign term_ext = $signed({{(F+1){mul_prod[2*DW]}}, mul_prod[2*DW:F]});
  assign flux_ext = $signed({{2{flux_sum_q[2*DW-1]}}, flux_sum_q});
  assign flux_add = flux_ext - term_ext;
  assign flux_ovf = !((&flux_add[uefc_pkg::SUM_W-1:2*DW-1]) ||
                      !(|flux_add[uefc_pkg::SUM_W-1:2*DW-1]));
  assign flux_nx  = flux_ovf ? (flux_add[uefc_pkg::SUM_W-1] ? {1'b1, {(2*DW-1){1'b0}}}
                                                            : {1'b0, {(2*DW-1){1'b1}}})
                             : flux_add[2*DW-1:0];

  // radius over speed operands
  assign speed = nvel_q[DW-1] ? (DW'(0) - nvel_q) : nvel_q;
  assign r_hi  = {{(DW-F){1'b0}}, radius_q[DW-1:DW-F]};
  assign r_lo  = {radius_q[DW-F-1:0], {F{1'b0}}};
  assign r_ovf = (r_hi >= speed);

  // sum over area operands
  assign a_hi  = mag_q[2*DW-1:DW-F];
  assign a_lo  = {mag_q[DW-F-1:0], {F{1'b0}}};
  assign a_ovf = (a_hi >= {{F{1'b0}}, area_q});

  assign limit      = neg_q ? uefc_pkg::NEG_LIMIT : uefc_pkg::POS_LIMIT;
  assign q_over     = (div_rsp.quot > limit);
  assign total      = q_over ? limit : div_rsp.quot;
  assign signed_res = neg_q ? (DW'(0) - total) : total;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_MUL_X: begin
        mul_a = {vel_x_q[DW-1], vel_x_q};
        mul_b = {{(uefc_pkg::MUL_W-uefc_pkg::NORM_W){nx_q[uefc_pkg::NORM_W-1]}}, nx_q};
      end
      ST_MUL_Y: begin
        mul_a = {vel_y_q[DW-1], vel_y_q};
        mul_b = {{(uefc_pkg::MUL_W-uefc_pkg::NORM_W){ny_q[uefc_pkg::NORM_W-1]}}, ny_q};
      end
      ST_MUL_E: begin
        mul_a = nvel_q[DW-1] ? {nbr_q[DW-1], nbr_q} : {own_q[DW-1], own_q};
        mul_b = {nvel_q[DW-1], nvel_q};
      end
      ST_MUL_T: begin
        mul_a = {ef_q[DW-1], ef_q};
        mul_b = {1'b0, len_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    div_req.start   = 1'b0;
    div_req.hi      = r_hi;
    div_req.lo      = r_lo;
    div_req.divisor = speed;
    if (state_q == ST_AREA) begin
      div_req.hi      = a_hi[DW-1:0];
      div_req.lo      = a_lo;
      div_req.divisor = area_q;
      div_req.start   = (area_q != '0) && !a_ovf;
    end else if (state_q == ST_ACC) begin
      div_req.start = full_q && (speed != '0) && !r_ovf;
    end
  end

  uefc_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (mul_prod)
  );

  uefc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_x_q     <= '0;
      vel_y_q     <= '0;
      huge_step_q <= uefc_pkg::HUGE_STEP_RST;
      max_step_q  <= uefc_pkg::MAX_STEP_RST;
    end else if (cfg_valid_i) begin
      unique case (uefc_pkg::reg_idx_e'(cfg_index_i))
        uefc_pkg::REG_VELOCITY_X: vel_x_q     <= cfg_data_i;
        uefc_pkg::REG_VELOCITY_Y: vel_y_q     <= cfg_data_i;
        uefc_pkg::REG_HUGE_STEP:  huge_step_q <= cfg_data_i;
        uefc_pkg::REG_MAX_STEP:   max_step_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      own_q    <= s_axis_tdata_i[31:0];
      nbr_q    <= s_axis_tdata_i[63:32];
      nx_q     <= s_axis_tdata_i[79:64];
      ny_q     <= s_axis_tdata_i[95:80];
      len_q    <= s_axis_tdata_i[127:96];
      area_q   <= s_axis_tdata_i[159:128];
      radius_q <= s_axis_tdata_i[191:160];
      full_q   <= s_axis_tuser_i[0];
      last_q   <= s_axis_tlast_i;
    end
    unique case (state_q)
      ST_MUL_Y: acc_q  <= $signed(mul_prod[uefc_pkg::NV_SUM_W-1:0]);
      ST_NVEL:  nvel_q <= nv_sat;
      ST_EF:    ef_q   <= ef_sat;
      ST_LAST: begin
        neg_q <= flux_sum_q[2*DW-1];
        mag_q <= flux_sum_q[2*DW-1] ? ((2*DW)'(0) - flux_sum_q) : flux_sum_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      flux_sum_q   <= '0;
      cell_step_q  <= uefc_pkg::HUGE_STEP_RST;
      sweep_step_q <= uefc_pkg::MAX_STEP_RST;
      cell_open_q  <= 1'b0;
      cell_sat_q   <= 1'b0;
      res_q        <= '0;
      res_sat_q    <= 1'b0;
      m_valid_q    <= 1'b0;
      out_flux_q   <= '0;
      out_step_q   <= '0;
      out_sat_q    <= 1'b0;
    end else begin
      if (m_valid_q && m_axis_tready_i && (state_q != ST_EMIT)) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            state_q <= ST_MUL_X;
            if (s_axis_tuser_i[1]) begin
              sweep_step_q <= max_step_q;
            end
            if (!cell_open_q) begin
              flux_sum_q  <= '0;
              cell_step_q <= huge_step_q;
              cell_sat_q  <= 1'b0;
              cell_open_q <= 1'b1;
            end
          end
        end
        ST_MUL_X: state_q <= ST_MUL_Y;
        ST_MUL_Y: state_q <= ST_NVEL;
        ST_NVEL:  state_q <= ST_MUL_E;
        ST_MUL_E: state_q <= ST_EF;
        ST_EF:    state_q <= ST_MUL_T;
        ST_MUL_T: state_q <= ST_ACC;
        ST_ACC: begin
          flux_sum_q <= flux_nx;
          if (full_q && (speed != '0)) begin
            if (r_ovf) begin
              cell_sat_q <= 1'b1;
              state_q    <= ST_LAST;
            end else begin
              state_q <= ST_RDIV;
            end
          end else begin
            state_q <= ST_LAST;
          end
        end
        ST_RDIV: begin
          if (div_rsp.done) begin
            if (div_rsp.quot < cell_step_q) begin
              cell_step_q <= div_rsp.quot;
            end
            state_q <= ST_LAST;
          end
        end
        ST_LAST: begin
          if (last_q) begin
            if (cell_step_q < sweep_step_q) begin
              sweep_step_q <= cell_step_q;
            end
            state_q <= ST_AREA;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_AREA: begin
          if (area_q == '0) begin
            res_sat_q <= 1'b1;
            res_q     <= (mag_q == '0) ? '0 : limit;
            state_q   <= ST_EMIT;
          end else if (a_ovf) begin
            res_sat_q <= 1'b1;
            res_q     <= limit;
            state_q   <= ST_EMIT;
          end else begin
            res_sat_q <= cell_sat_q;
            state_q   <= ST_ADIV;
          end
        end
        ST_ADIV: begin
          if (div_rsp.done) begin
            res_q     <= signed_res;
            res_sat_q <= res_sat_q || q_over;
            state_q   <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!m_valid_q || m_axis_tready_i) begin
            out_flux_q  <= res_q;
            out_step_q  <= sweep_step_q;
            out_sat_q   <= res_sat_q;
            m_valid_q   <= 1'b1;
            cell_open_q <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o   = m_valid_q;
  assign m_axis_tdata_o    = {out_step_q, out_flux_q};
  assign m_axis_tuser_o[0] = out_sat_q;

  `UEFC_ASSERT_SAME(a_div_in_wait, clk_i, rst_ni, div_rsp.busy,
    (state_q == ST_RDIV) || (state_q == ST_ADIV))
  `UEFC_ASSERT_NEXT(a_busy_after_item, clk_i, rst_ni, in_acc, !s_axis_tready_o)
  `UEFC_ASSERT_SAME(a_emit_on_last, clk_i, rst_ni, state_q == ST_EMIT, last_q)
  `UEFC_ASSERT_SAME(a_sweep_bound, clk_i, rst_ni, state_q == ST_EMIT,
    sweep_step_q <= cell_step_q)

endmodule

`default_nettype wire

>>> tb/sv/upwind_edge_flux_cfl_step_unit_tb.sv
// ----------------------------------------------------------------------------
// upwind_edge_flux_cfl_step_unit_tb
// Streams triangle edges into the flux and timestep unit. A predictor keeps
// its own flux sum, cell and sweep bounds, and queues the expected cell
// results. A checker compares every result field by field. Directed cases
// cover field extremes, upwind side selection, zero area, division overflow
// and long cells. Random phases follow with several register settings and
// with idle and stall patterns on both sides.
// ----------------------------------------------------------------------------
module upwind_edge_flux_cfl_step_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     SETTLE_CYCLES = 100;
  localparam longint INT32_HI      = 64'sd2147483647;
  localparam longint INT32_LO      = -64'sd2147483648;
  localparam longint SUM_HI        = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint SUM_LO        = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic signed [31:0] own_value;
    logic signed [31:0] neighbour_value;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic [31:0]        edge_length;
    logic [31:0]        cell_area;
    logic [31:0]        cell_radius;
    logic               full_cell;
    logic               last_edge;
    logic               new_sweep;
  } edge_item_t;

  typedef struct packed {
    logic [31:0] flux_update;
    logic [31:0] step_limit;
    logic        saturated;
  } cell_result_t;

  logic         clk_i = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_valid = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;
  logic         s_valid = 1'b0;
  logic [191:0] s_data = '0;
  logic         s_last = 1'b0;
  logic [1:0]   s_user = '0;
  logic         m_ready = 1'b0;
  logic         cfg_ready_o;
  logic         s_axis_tready_o;
  logic         m_axis_tvalid_o;
  logic [63:0]  m_axis_tdata_o;
  logic [0:0]   m_axis_tuser_o;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int errors         = 0;
  int edges_sent     = 0;
  int results_seen   = 0;
  int sat_seen       = 0;
  int reg_writes     = 0;

  // predictor state
  logic signed [31:0] vel_x = '0;
  logic signed [31:0] vel_y = '0;
  logic [31:0]        huge_step_q = uefc_pkg::HUGE_STEP_RST;
  logic [31:0]        max_step_q = uefc_pkg::MAX_STEP_RST;
  longint             flux_acc = 0;
  logic [31:0]        cell_bound = uefc_pkg::HUGE_STEP_RST;
  logic [31:0]        sweep_bound = uefc_pkg::MAX_STEP_RST;
  bit                 cell_open = 1'b0;
  bit                 cell_ovf = 1'b0;
  cell_result_t       cell_results[$];

  upwind_edge_flux_cfl_step_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk_i) begin
    m_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    cell_result_t want;
    if (rst_n && m_axis_tvalid_o && m_ready) begin
      if (cell_results.size() == 0) begin
        $error("result with no expectation: flux %h step %h sat %b",
               m_axis_tdata_o[31:0], m_axis_tdata_o[63:32], m_axis_tuser_o[0]);
        errors++;
      end else begin
        want = cell_results.pop_front();
        results_seen++;
        if (m_axis_tuser_o[0] === 1'b1) sat_seen++;
        if (m_axis_tdata_o[31:0] !== want.flux_update) begin
          $error("flux_update: expected %h, got %h", want.flux_update, m_axis_tdata_o[31:0]);
          errors++;
        end
        if (m_axis_tdata_o[63:32] !== want.step_limit) begin
          $error("step_limit: expected %h, got %h", want.step_limit, m_axis_tdata_o[63:32]);
          errors++;
        end
        if (m_axis_tuser_o[0] !== want.saturated) begin
          $error("saturated: expected %b, got %b", want.saturated, m_axis_tuser_o[0]);
          errors++;
        end
      end
    end
  end

  function automatic longint clamp_to_int32(longint x);
    if (x > INT32_HI) return INT32_HI;
    if (x < INT32_LO) return INT32_LO;
    return x;
  endfunction

  task automatic predict_edge(input edge_item_t e);
    longint       nvel, ef, term, neg_term;
    logic [63:0]  speed, ratio, mag, quot, rem, total, limit;
    cell_result_t res;
    bit           neg;
    if (e.new_sweep) sweep_bound = max_step_q;
    if (!cell_open) begin
      flux_acc = 0;
      cell_bound = huge_step_q;
      cell_ovf = 1'b0;
      cell_open = 1'b1;
    end
    nvel = clamp_to_int32((longint'(vel_x) * longint'($signed(e.normal_x)) +
                           longint'(vel_y) * longint'($signed(e.normal_y)))
                          >>> uefc_pkg::NORM_FRAC);
    ef = clamp_to_int32(((nvel < 0) ? longint'($signed(e.neighbour_value))
                                    : longint'($signed(e.own_value))) * nvel
                        >>> uefc_pkg::FRACTION_BITS);
    term = (ef * longint'(e.edge_length)) >>> uefc_pkg::FRACTION_BITS;
    neg_term = -term;
    if (neg_term > 0 && flux_acc > SUM_HI - neg_term) flux_acc = SUM_HI;
    else if (neg_term < 0 && flux_acc < SUM_LO - neg_term) flux_acc = SUM_LO;
    else flux_acc = flux_acc + neg_term;

    speed = (nvel < 0) ? 64'(-nvel) : 64'(nvel);
    if (e.full_cell && speed != 0) begin
      ratio = ({32'b0, e.cell_radius} << uefc_pkg::FRACTION_BITS) / speed;
      if (ratio > 64'hFFFF_FFFF) begin
        ratio = 64'hFFFF_FFFF;
        cell_ovf = 1'b1;
      end
      if ({32'b0, cell_bound} > ratio) cell_bound = ratio[31:0];
    end
    if (!e.last_edge) return;

    res.saturated = cell_ovf;
    neg = flux_acc < 0;
    mag = neg ? 64'(-flux_acc) : 64'(flux_acc);
    limit = neg ? {32'b0, uefc_pkg::NEG_LIMIT} : {32'b0, uefc_pkg::POS_LIMIT};
    if (e.cell_area == 0) begin
      res.saturated = 1'b1;
      total = (mag == 0) ? 64'd0 : limit;
    end else begin
      quot = mag / e.cell_area;
      rem = mag % e.cell_area;
      if (quot > (64'h8000_0000 >> uefc_pkg::FRACTION_BITS)) total = limit + 1;
      else total = (quot << uefc_pkg::FRACTION_BITS) +
                   ((rem << uefc_pkg::FRACTION_BITS) / e.cell_area);
      if (total > limit) begin
        res.saturated = 1'b1;
        total = limit;
      end
    end
    res.flux_update = neg ? (32'd0 - total[31:0]) : total[31:0];
    if (sweep_bound > cell_bound) sweep_bound = cell_bound;
    res.step_limit = sweep_bound;
    cell_results.push_back(res);
    cell_open = 1'b0;
    cell_ovf = 1'b0;
    flux_acc = 0;
    cell_bound = huge_step_q;
  endtask

  task automatic send_edge(input edge_item_t e);
    while ($urandom_range(99) < src_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= {e.cell_radius, e.cell_area, e.edge_length, e.normal_y, e.normal_x,
               e.neighbour_value, e.own_value};
    s_last <= e.last_edge;
    s_user <= {e.new_sweep, e.full_cell};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_edge(e);
    edges_sent++;
  endtask

  task automatic wait_results(input int settle);
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (cell_results.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_register(input uefc_pkg::reg_idx_e idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid <= 1'b0;
    unique case (idx)
      uefc_pkg::REG_VELOCITY_X: vel_x = value;
      uefc_pkg::REG_VELOCITY_Y: vel_y = value;
      uefc_pkg::REG_HUGE_STEP:  huge_step_q = value;
      uefc_pkg::REG_MAX_STEP:   max_step_q = value;
      default: ;
    endcase
    reg_writes++;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [31:0] vx, input logic [31:0] vy,
                           input logic [31:0] huge, input logic [31:0] maxs);
    wait_results(SETTLE_CYCLES);
    write_register(uefc_pkg::REG_VELOCITY_X, vx);
    write_register(uefc_pkg::REG_VELOCITY_Y, vy);
    write_register(uefc_pkg::REG_HUGE_STEP, huge);
    write_register(uefc_pkg::REG_MAX_STEP, maxs);
  endtask

  function automatic edge_item_t make_edge(
    input logic [31:0] own, input logic [31:0] nb, input logic [15:0] nx,
    input logic [15:0] ny, input logic [31:0] len, input logic [31:0] area,
    input logic [31:0] radius, input bit full, input bit is_last, input bit sweep);
    edge_item_t e;
    e.own_value = own;
    e.neighbour_value = nb;
    e.normal_x = nx;
    e.normal_y = ny;
    e.edge_length = len;
    e.cell_area = area;
    e.cell_radius = radius;
    e.full_cell = full;
    e.last_edge = is_last;
    e.new_sweep = sweep;
    return e;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0: return 32'h0000_0000;
          1: return 32'h0000_0001;
          2: return 32'h7FFF_FFFF;
          3: return 32'h8000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1, 2: return $urandom();
      default: return 32'($urandom_range(2097152)) - 32'd1048576;
    endcase
  endfunction

  function automatic logic [31:0] rand_magnitude();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(2))
          0: return 32'h0000_0000;
          1: return 32'h0000_0001;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1, 2: return $urandom();
      default: return $urandom_range(32'h0004_0000);
    endcase
  endfunction

  function automatic logic [31:0] rand_area();
    case ($urandom_range(9))
      0: return 32'h0;
      1: return $urandom_range(255, 1);
      2: return $urandom();
      default: return $urandom_range(32'h0008_0000, 32'h100);
    endcase
  endfunction

  function automatic logic [15:0] rand_normal();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(2))
          0: return 16'sd16384;
          1: return -16'sd16384;
          default: return 16'h0;
        endcase
      end
      default: return 16'($urandom_range(32768)) - 16'd16384;
    endcase
  endfunction

  function automatic edge_item_t random_edge(input bit is_first, input bit is_last);
    bit sweep;
    sweep = is_first ? ($urandom_range(99) < 15) : ($urandom_range(99) < 3);
    return make_edge(rand_value(), rand_value(), rand_normal(), rand_normal(),
                     rand_magnitude(), rand_area(), rand_magnitude(),
                     $urandom_range(99) < 70, is_last, sweep);
  endfunction

  task automatic test_reset_state();
    send_edge(make_edge(32'h1_0000, 32'hFFFF_FFFF, 16'sd16384, 16'h0, 32'h1_0000, 32'h0,
                        32'h1_0000, 1'b1, 1'b0, 1'b0));
    send_edge(make_edge(32'h2_0000, 32'h3_0000, 16'h0, -16'sd16384, 32'h1_0000, 32'h0,
                        32'h1_0000, 1'b1, 1'b0, 1'b0));
    send_edge(make_edge(32'h0, 32'h0, 16'sd16384, 16'sd16384, 32'h1_0000, 32'h0,
                        32'h1_0000, 1'b1, 1'b1, 1'b0));
    wait_results(SETTLE_CYCLES);
  endtask

  task automatic test_upwind_choice();
    configure(32'h0001_0000, 32'h0000_8000, uefc_pkg::HUGE_STEP_RST,
              uefc_pkg::MAX_STEP_RST);
    send_edge(make_edge(32'h3_0000, 32'hFFFD_0000, 16'sd16384, 16'h0, 32'h1_0000,
                        32'h3_0000, 32'h0_8000, 1'b1, 1'b0, 1'b1));
    send_edge(make_edge(32'h3_0000, 32'hFFFD_0000, -16'sd16384, 16'h0, 32'h2_0000,
                        32'h3_0000, 32'h0_8000, 1'b1, 1'b0, 1'b0));
    send_edge(make_edge(32'h1_0000, 32'h5_0000, 16'h0, -16'sd16384, 32'h1_8000,
                        32'h3_0000, 32'h0_4000, 1'b1, 1'b0, 1'b0));
    // zero normal speed: bound stays put
    send_edge(make_edge(32'h7_0000, 32'h9_0000, -16'sd8192, 16'sd16384, 32'h1_0000,
                        32'h3_0000, 32'h0, 1'b1, 1'b1, 1'b0));
    wait_results(SETTLE_CYCLES);
  endtask

  task automatic test_zero_area_sign();
    send_edge(make_edge(32'h2_0000, 32'h0, 16'sd16384, 16'h0, 32'h1_0000, 32'h0,
                        32'h0, 1'b1, 1'b1, 1'b0));
    send_edge(make_edge(32'hFFFE_0000, 32'h0, 16'sd16384, 16'h0, 32'h1_0000, 32'h0,
                        32'h0, 1'b1, 1'b1, 1'b1));
    wait_results(SETTLE_CYCLES);
  endtask

  task automatic test_field_extremes();
    configure(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_edge(make_edge(32'h7FFF_FFFF, 32'h8000_0000, 16'sd16384, -16'sd16384,
                        32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1));
    send_edge(make_edge(32'h7FFF_FFFF, 32'h8000_0000, -16'sd16384, 16'sd16384,
                        32'h0, 32'h1, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0));
    // speed of one: radius division overflows
    send_edge(make_edge(32'h0, 32'h8000_0000, 16'sd1, 16'sd1, 32'hFFFF_FFFF, 32'h1,
                        32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0));
    send_edge(make_edge(32'h1, 32'hFFFF_FFFF, -16'sd16384, -16'sd16384, 32'h1,
                        32'hFFFF_FFFF, 32'h0, 1'b0, 1'b1, 1'b0));
    wait_results(SETTLE_CYCLES);
  endtask

  task automatic test_long_cell();
    int k;
    configure(32'h0001_8000, 32'hFFFF_C000, 32'h0002_0000, 32'h0000_8000);
    for (k = 0; k < 6; k++) begin
      send_edge(make_edge(32'h1_0000 + 32'(k) * 32'h4000, 32'hFFFF_0000 - 32'(k),
                          (k % 2) ? -16'sd11585 : 16'sd11585, 16'sd11585,
                          32'h1_0000, 32'h2_0000, 32'h0_4000 + 32'(k), 1'b1,
                          k == 5, k == 0));
    end
    send_edge(make_edge(32'h5_0000, 32'h0, 16'sd16384, 16'h0, 32'h1_0000, 32'h2_0000,
                        32'h0, 1'b0, 1'b1, 1'b0));
    wait_results(SETTLE_CYCLES);
  endtask

  task automatic test_register_timing();
    configure(32'h0001_0000, 32'h0, 32'h0, 32'h0);
    send_edge(make_edge(32'h1_0000, 32'h1_0000, 16'sd16384, 16'h0, 32'h1_0000,
                        32'h1_0000, 32'h1_0000, 1'b0, 1'b1, 1'b0));
    send_edge(make_edge(32'h1_0000, 32'h1_0000, 16'sd16384, 16'h0, 32'h1_0000,
                        32'h1_0000, 32'h1_0000, 1'b0, 1'b1, 1'b1));
    wait_results(SETTLE_CYCLES);
  endtask

  task automatic test_random_cells(input int n_items, input int src_pct, input int sink_pct,
                                   input bit hold_midway);
    int start_count;
    int n_edges;
    int k;
    bit held;
    held = 1'b0;
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    start_count = edges_sent;
    while (edges_sent - start_count < n_items) begin
      if (hold_midway && !held && edges_sent - start_count >= n_items / 2) begin
        wait_results(0);
        held = 1'b1;
      end
      n_edges = ($urandom_range(9) < 8) ? 3 : $urandom_range(6, 1);
      for (k = 0; k < n_edges; k++) send_edge(random_edge(k == 0, k == n_edges - 1));
    end
    wait_results(SETTLE_CYCLES);
    src_idle_pct = 0;
    sink_stall_pct = 0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_upwind_choice();
    test_zero_area_sign();
    test_field_extremes();
    test_long_cell();
    test_register_timing();

    configure(32'h0001_0000, 32'hFFFF_8000, 32'hFFFF_FFFF, 32'h0001_0000);
    test_random_cells(250, 0, 0, 1'b0);
    configure(32'($urandom_range(32'h8_0000)) - 32'h4_0000,
              32'($urandom_range(32'h8_0000)) - 32'h4_0000, 32'h0004_0000, 32'hFFFF_FFFF);
    test_random_cells(250, 49, 0, 1'b1);
    configure(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0002_0000);
    test_random_cells(250, 0, 49, 1'b0);
    configure($urandom(), 32'h0, $urandom(), $urandom());
    test_random_cells(250, 36, 36, 1'b0);
    configure(32'h0, 32'h0003_0000, 32'hFFFF_FFFF, 32'h0);
    test_random_cells(250, 0, 0, 1'b0);
    configure(32'($urandom_range(32'h2_0000)) - 32'h1_0000,
              32'($urandom_range(32'h2_0000)) - 32'h1_0000, 32'h0010_0000, 32'h0008_0000);
    test_random_cells(250, 36, 36, 1'b1);

    wait_results(SETTLE_CYCLES);
    $display("checked %0d cell results from %0d edges, %0d of them flagged saturated",
             results_seen, edges_sent, sat_seen);
    $display("%0d register writes across directed cases and six random phases",
             reg_writes);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
